// File: rtl/gn3_pkg.sv
// shared types, constants and the gradient select function for the noise unit
package gn3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TBL_AW    = 8;
    localparam int VAL_W     = 20;
    localparam int OUT_W     = 19;

    typedef logic [TBL_AW-1:0]           t_byte;
    typedef logic [FRAC_BITS-1:0]        t_frac;
    typedef logic signed [FRAC_BITS:0]   t_off;
    typedef logic [FRAC_BITS:0]          t_blend;
    typedef logic signed [VAL_W-1:0]     t_val;
    typedef logic signed [OUT_W-1:0]     t_out;

    localparam logic [FRAC_BITS:0] ONE      = 17'(1) << FRAC_BITS;
    localparam logic [37:0]        HALF_P   = 38'(1) << (FRAC_BITS - 1);
    localparam logic [33:0]        HALF_F   = 34'(1) << (FRAC_BITS - 1);
    localparam t_val               OUT_MAXV = 20'sd262143;
    localparam t_val               OUT_MINV = -20'sd262144;

    // one of 12 gradient sums picked by the low hash bits; codes 12 to 15 repeat four of them
    function automatic t_val grad(input logic [3:0] h, input t_off x, input t_off y,
                                  input t_off z);
        t_val ex, ey, ez, r;
        ex = VAL_W'(x);
        ey = VAL_W'(y);
        ez = VAL_W'(z);
        case (h)
            4'd0:    r =  ex + ey;
            4'd1:    r = -ex + ey;
            4'd2:    r =  ex - ey;
            4'd3:    r = -ex - ey;
            4'd4:    r =  ex + ez;
            4'd5:    r = -ex + ez;
            4'd6:    r =  ex - ez;
            4'd7:    r = -ex - ez;
            4'd8:    r =  ey + ez;
            4'd9:    r = -ey + ez;
            4'd10:   r =  ey - ez;
            4'd11:   r = -ey - ez;
            4'd12:   r =  ex + ey;
            4'd13:   r = -ex + ey;
            4'd14:   r =  ey - ez;
            default: r = -ey - ez;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/gn3_perm_ram.sv
// one copy of the permutation table: one write port, two registered read ports
module gn3_perm_ram
    import gn3_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_ce,
    input  logic  i_we,
    input  t_byte i_waddr,
    input  t_byte i_wdata,
    input  t_byte i_raddr_a,
    input  t_byte i_raddr_b,
    output t_byte o_rdata_a,
    output t_byte o_rdata_b
);

    t_byte r_mem [2**TBL_AW];
    t_byte r_rd_a, r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (i_we) begin
                r_mem[i_waddr] <= i_wdata;
            end
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// File: rtl/gn3_fade.sv
// two-stage fade curve 3t^2 - 2t^3
module gn3_fade
    import gn3_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_ce,
    input  t_frac  i_t,
    output t_blend o_s
);

    logic [FRAC_BITS:0]   r_t2;
    logic [FRAC_BITS+1:0] r_k;
    t_blend               r_s;
    logic [31:0]          n_sq;
    logic [33:0]          n_cu;

    always_comb begin
        n_sq = 32'(i_t) * 32'(i_t);
        n_cu = 34'(r_t2) * 34'(r_k) + HALF_F;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_t2 <= 17'((33'(n_sq) + 33'(HALF_F)) >> FRAC_BITS);
            r_k  <= (18'(3) << FRAC_BITS) - {1'b0, i_t, 1'b0};
            r_s  <= 17'(n_cu >> FRAC_BITS);
        end
    end

    assign o_s = r_s;

endmodule

// File: rtl/gn3_lerp.sv
// two-stage linear blend a + round((b - a) * s)
module gn3_lerp
    import gn3_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_ce,
    input  t_val   i_a,
    input  t_val   i_b,
    input  t_blend i_s,
    output t_val   o_r
);

    logic signed [37:0] r_p;
    t_val               r_a;
    t_val               r_r;
    t_val               n_d;
    logic signed [37:0] n_rnd;

    always_comb begin
        n_d   = i_b - i_a;
        n_rnd = (r_p + $signed(HALF_P)) >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p <= 38'(n_d) * $signed({1'b0, i_s});
            r_a <= i_a;
            r_r <= r_a + VAL_W'(n_rnd);
        end
    end

    assign o_r = r_r;

endmodule

// File: rtl/gradient_noise_3d_unit.sv
// top level of the 3-d gradient noise pipeline
// Takes one word per cycle while the pipeline advances. Each evaluate word passes
// through twelve register stages and its noise word is valid once it reaches the
// output register. A load word writes one permutation byte and returns nothing. The
// whole pipeline moves together and halts only while the output register holds a word
// that the sink has not taken. The permutation table is held in seven copies over the
// three lookup levels of the corner hash (one copy for the x level, two for y, four
// for z), each read at two addresses per cycle. A load travels down the pipe and
// writes each copy as it passes that copy's level, so every evaluate word sees exactly
// the loads ahead of it. Entries must be loaded before any evaluate word reads them.
module gradient_noise_3d_unit
    import gn3_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // coord_x, coord_y, coord_z, wrap_mask, entry_index, entry_value
    input  logic [119:0] i_s_axis_tdata,
    // func
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // noise_value, zero padded
    output logic [23:0]  o_m_axis_tdata
);

    localparam int LAST = 12;

    // valid bits: eval along the whole pipe, load down to the last table level
    logic [LAST:1] r_ev;
    logic [3:1]    r_ld;

    // global advance: everything moves when the output slot is free or taken
    logic ce;
    assign ce = !r_ev[LAST] || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    // input word fields
    t_byte in_mask, in_ix, in_val;
    t_byte fx, fy, fz;
    assign fx      = i_s_axis_tdata[23:16];
    assign fy      = i_s_axis_tdata[55:48];
    assign fz      = i_s_axis_tdata[87:80];
    assign in_mask = i_s_axis_tdata[103:96];
    assign in_ix   = i_s_axis_tdata[111:104];
    assign in_val  = i_s_axis_tdata[119:112];

    // load payload
    t_byte r_ix [1:3];
    t_byte r_val [1:3];

    // lattice indices
    t_byte r_x0, r_x1, r_y0 [1:2], r_y1 [1:2], r_z0 [1:3], r_z1 [1:3];
    // fractions, carried to the gradient stage
    t_frac r_tx [1:4], r_ty [1:4], r_tz [1:4];
    // fade results delayed to their blend stage
    t_blend r_sx [4:9], r_sy [4:7], r_sz [4:5];
    // corner gradients
    t_val r_g [8];
    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= '0;
            r_ld <= '0;
        end else if (ce) begin
            r_ev <= {r_ev[LAST-1:1], i_s_axis_tvalid && i_s_axis_tuser};
            r_ld <= {r_ld[2:1], i_s_axis_tvalid && !i_s_axis_tuser};
        end
    end

    // stage 1: floor, wrap and fractions
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x0    <= fx & in_mask;
            r_x1    <= (fx + 8'd1) & in_mask;
            r_y0[1] <= fy & in_mask;
            r_y1[1] <= (fy + 8'd1) & in_mask;
            r_z0[1] <= fz & in_mask;
            r_z1[1] <= (fz + 8'd1) & in_mask;
            r_tx[1] <= i_s_axis_tdata[15:0];
            r_ty[1] <= i_s_axis_tdata[47:32];
            r_tz[1] <= i_s_axis_tdata[79:64];
            r_ix[1] <= in_ix;
            r_val[1] <= in_val;
            for (int k = 2; k <= 3; k++) begin
                r_ix[k]  <= r_ix[k-1];
                r_val[k] <= r_val[k-1];
                r_z0[k]  <= r_z0[k-1];
                r_z1[k]  <= r_z1[k-1];
            end
            r_y0[2] <= r_y0[1];
            r_y1[2] <= r_y1[1];
            for (int k = 2; k <= 4; k++) begin
                r_tx[k] <= r_tx[k-1];
                r_ty[k] <= r_ty[k-1];
                r_tz[k] <= r_tz[k-1];
            end
        end
    end

    // fade curves, ready at stage 3
    t_blend sx3, sy3, sz3;
    gn3_fade u_fade_x (.i_clk(i_clk), .i_ce(ce), .i_t(r_tx[1]), .o_s(sx3));
    gn3_fade u_fade_y (.i_clk(i_clk), .i_ce(ce), .i_t(r_ty[1]), .o_s(sy3));
    gn3_fade u_fade_z (.i_clk(i_clk), .i_ce(ce), .i_t(r_tz[1]), .o_s(sz3));

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sx[4] <= sx3;
            r_sy[4] <= sy3;
            r_sz[4] <= sz3;
            for (int k = 5; k <= 9; k++) r_sx[k] <= r_sx[k-1];
            for (int k = 5; k <= 7; k++) r_sy[k] <= r_sy[k-1];
            r_sz[5] <= r_sz[4];
        end
    end

    // hash level x: h0, h1 at stage 2
    t_byte h0, h1;
    gn3_perm_ram u_ram_x (
        .i_clk(i_clk), .i_ce(ce), .i_we(r_ld[1]), .i_waddr(r_ix[1]), .i_wdata(r_val[1]),
        .i_raddr_a(r_x0), .i_raddr_b(r_x1), .o_rdata_a(h0), .o_rdata_b(h1)
    );

    // hash level y: a0..a3 at stage 3
    t_byte a [4];
    gn3_perm_ram u_ram_y0 (
        .i_clk(i_clk), .i_ce(ce), .i_we(r_ld[2]), .i_waddr(r_ix[2]), .i_wdata(r_val[2]),
        .i_raddr_a(h0 + r_y0[2]), .i_raddr_b(h0 + r_y1[2]),
        .o_rdata_a(a[0]), .o_rdata_b(a[2])
    );
    gn3_perm_ram u_ram_y1 (
        .i_clk(i_clk), .i_ce(ce), .i_we(r_ld[2]), .i_waddr(r_ix[2]), .i_wdata(r_val[2]),
        .i_raddr_a(h1 + r_y0[2]), .i_raddr_b(h1 + r_y1[2]),
        .o_rdata_a(a[1]), .o_rdata_b(a[3])
    );

    // hash level z: eight corner hashes at stage 4, corner bit 2 selects z1
    t_byte hc [8];
    for (genvar j = 0; j < 4; j++) begin : g_ram_z
        gn3_perm_ram u_ram_z (
            .i_clk(i_clk), .i_ce(ce), .i_we(r_ld[3]), .i_waddr(r_ix[3]),
            .i_wdata(r_val[3]),
            .i_raddr_a(a[j] + r_z0[3]), .i_raddr_b(a[j] + r_z1[3]),
            .o_rdata_a(hc[j]), .o_rdata_b(hc[j+4])
        );
    end

    // stage 5: corner gradients; corner bit set means offset t - 1
    t_off ox0, ox1, oy0, oy1, oz0, oz1;
    always_comb begin
        ox0 = $signed({1'b0, r_tx[4]});
        oy0 = $signed({1'b0, r_ty[4]});
        oz0 = $signed({1'b0, r_tz[4]});
        ox1 = ox0 - $signed(ONE);
        oy1 = oy0 - $signed(ONE);
        oz1 = oz0 - $signed(ONE);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 8; i++) begin
                r_g[i] <= grad(hc[i][3:0], i[0] ? ox1 : ox0, i[1] ? oy1 : oy0,
                               i[2] ? oz1 : oz0);
            end
        end
    end

    // blend along z (stage 7), y (stage 9), x (stage 11)
    t_val bz [4];
    t_val by [2];
    t_val bx;
    for (genvar j = 0; j < 4; j++) begin : g_lerp_z
        gn3_lerp u_lerp_z (.i_clk(i_clk), .i_ce(ce), .i_a(r_g[j]), .i_b(r_g[j+4]),
                           .i_s(r_sz[5]), .o_r(bz[j]));
    end
    for (genvar j = 0; j < 2; j++) begin : g_lerp_y
        gn3_lerp u_lerp_y (.i_clk(i_clk), .i_ce(ce), .i_a(bz[j]), .i_b(bz[j+2]),
                           .i_s(r_sy[7]), .o_r(by[j]));
    end
    gn3_lerp u_lerp_x (.i_clk(i_clk), .i_ce(ce), .i_a(by[0]), .i_b(by[1]),
                       .i_s(r_sx[9]), .o_r(bx));

    // stage 12: saturate into the output register
    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (bx > OUT_MAXV) begin
                r_out <= OUT_MAXV[OUT_W-1:0];
            end else if (bx < OUT_MINV) begin
                r_out <= OUT_MINV[OUT_W-1:0];
            end else begin
                r_out <= bx[OUT_W-1:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_ev[LAST];
    assign o_m_axis_tdata  = {5'd0, r_out};

endmodule
